@@ hdl/sha512_pkg.sv @@
package sha512_pkg;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_ROUND,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	localparam logic [63:0] IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] KROUND [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned ROUNDS = 80;

endpackage

@@ hdl/sha512_hash_engine.sv @@
// SHA-512 engine. Message words enter on start while busy is low. A non-last
// word leaves busy low unless it completes a block, which starts a compression
// (80 rounds at one a cycle through a single round unit, and the hash update).
// A last word runs the padding one word per cycle, one or two compressions,
// then gives the eight digest words on consecutive cycles with done high; the
// receiver cannot stall them, and busy stays high until the last one has gone.
module sha512_hash_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  sha512_pkg::in_item_t  in_item,
	output logic                  busy,
	output logic                  done,
	output sha512_pkg::out_item_t out_item
);

	sha512_pkg::state_t state_q, state_d;

	logic [63:0] hash_q [8];
	logic [63:0] var_q  [8];
	logic [63:0] buf_q  [16];
	logic [63:0] w_q    [16];
	logic [63:0] len_q;
	logic [3:0]  fill_q;
	logic [6:0]  rnd_q;
	logic [2:0]  emit_q;
	logic        pad_q;      // padding in progress
	logic        pad2_q;     // second padding word (0x80 after full last word)
	logic        late_q;     // 0x80 word sits in slot 14, slot 15 stays zero

	// length word has been pushed in the current padding run
	logic len_done_q;

	logic [63:0] push_word;
	logic        push_en;
	logic [3:0]  nbytes;
	logic [63:0] mask, kept;
	logic [5:0]  psh;

	// round unit
	logic [63:0] wt, sa, sb, s0, s1, ch, maj, t1, t2;
	logic [3:0]  ri;

	assign ri = rnd_q[3:0];
	assign sa = w_q[4'(ri + 4'd1)];
	assign sb = w_q[4'(ri + 4'd14)];

	always_comb begin
		if (rnd_q < 7'd16)
			wt = buf_q[ri];
		else
			wt = w_q[ri] + ({sa[0], sa[63:1]} ^ {sa[7:0], sa[63:8]} ^ (sa >> 7))
				+ w_q[4'(ri + 4'd9)]
				+ ({sb[18:0], sb[63:19]} ^ {sb[60:0], sb[63:61]} ^ (sb >> 6));
		s1  = {var_q[4][13:0], var_q[4][63:14]} ^ {var_q[4][17:0], var_q[4][63:18]}
			^ {var_q[4][40:0], var_q[4][63:41]};
		ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		t1  = var_q[7] + s1 + ch + sha512_pkg::KROUND[rnd_q] + wt;
		s0  = {var_q[0][27:0], var_q[0][63:28]} ^ {var_q[0][33:0], var_q[0][63:34]}
			^ {var_q[0][38:0], var_q[0][63:39]};
		maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t2  = s0 + maj;
	end

	// word to push this cycle
	always_comb begin
		nbytes = (in_item.byte_count > 4'd8) ? 4'd8 : in_item.byte_count;
		psh    = 6'd56 - 6'({nbytes[2:0], 3'b000});
		mask   = (nbytes == 4'd0) ? 64'd0 : ~(64'hffff_ffff_ffff_ffff >> {nbytes, 3'b000});
		kept   = in_item.data_word & mask;
		push_en   = 1'b0;
		push_word = 64'd0;
		if (state_q == sha512_pkg::ST_IDLE && start) begin
			push_en = 1'b1;
			if (!in_item.last || nbytes == 4'd8)
				push_word = in_item.data_word;
			else
				push_word = kept | ({56'd0, sha512_pkg::PAD_BYTE} << psh);
		end else if (state_q == sha512_pkg::ST_PUSH) begin
			push_en = 1'b1;
			if (pad2_q)
				push_word = {sha512_pkg::PAD_BYTE, 56'd0};
			else if (fill_q == 4'd15 && !late_q)
				push_word = len_q;
			else
				push_word = 64'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != sha512_pkg::ST_IDLE);
		unique case (state_q)
			sha512_pkg::ST_IDLE:
				if (start) begin
					if (fill_q == 4'd15)
						state_d = sha512_pkg::ST_ROUND;
					else if (in_item.last)
						state_d = sha512_pkg::ST_PUSH;
				end
			sha512_pkg::ST_PUSH:
				if (fill_q == 4'd15)
					state_d = sha512_pkg::ST_ROUND;
			sha512_pkg::ST_ROUND:
				if (rnd_q == 7'(sha512_pkg::ROUNDS - 1))
					state_d = sha512_pkg::ST_UPDATE;
			sha512_pkg::ST_UPDATE:
				if (pad_q)
					state_d = (fill_q == 4'd0 && !pad2_q && len_done_q)
						? sha512_pkg::ST_EMIT : sha512_pkg::ST_PUSH;
				else
					state_d = sha512_pkg::ST_IDLE;
			sha512_pkg::ST_EMIT:
				if (emit_q == 3'd7)
					state_d = sha512_pkg::ST_IDLE;
			default: state_d = sha512_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sha512_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			rnd_q      <= '0;
			emit_q     <= '0;
			len_q      <= '0;
			pad_q      <= 1'b0;
			pad2_q     <= 1'b0;
			late_q     <= 1'b0;
			len_done_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha512_pkg::IV[i];
				var_q[i]  <= '0;
			end
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 4'd1;
				if (fill_q == 4'd14 && ((state_q == sha512_pkg::ST_IDLE && in_item.last
					&& nbytes != 4'd8) || (state_q == sha512_pkg::ST_PUSH && pad2_q)))
					late_q <= 1'b1;
				else if (fill_q == 4'd15)
					late_q <= 1'b0;
				if (state_q == sha512_pkg::ST_PUSH) begin
					pad2_q <= 1'b0;
					if (fill_q == 4'd15 && !pad2_q && !late_q)
						len_done_q <= 1'b1;
				end
				if (fill_q == 4'd15)
					for (int i = 0; i < 8; i++)
						var_q[i] <= hash_q[i];
			end
			if (state_q == sha512_pkg::ST_IDLE && start) begin
				if (!in_item.last) begin
					len_q <= len_q + 64'd64;
				end else begin
					len_q      <= len_q + {57'd0, nbytes, 3'b000};
					pad_q      <= 1'b1;
					pad2_q     <= (nbytes == 4'd8);
					len_done_q <= 1'b0;
				end
			end
			if (state_q == sha512_pkg::ST_ROUND) begin
				rnd_q    <= (rnd_q == 7'(sha512_pkg::ROUNDS - 1)) ? 7'd0 : rnd_q + 7'd1;
				var_q[7] <= var_q[6];
				var_q[6] <= var_q[5];
				var_q[5] <= var_q[4];
				var_q[4] <= var_q[3] + t1;
				var_q[3] <= var_q[2];
				var_q[2] <= var_q[1];
				var_q[1] <= var_q[0];
				var_q[0] <= t1 + t2;
			end
			if (state_q == sha512_pkg::ST_UPDATE)
				for (int i = 0; i < 8; i++)
					hash_q[i] <= hash_q[i] + var_q[i];
			if (state_q == sha512_pkg::ST_EMIT) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd7) begin
					for (int i = 0; i < 8; i++)
						hash_q[i] <= sha512_pkg::IV[i];
					len_q      <= '0;
					fill_q     <= '0;
					pad_q      <= 1'b0;
					len_done_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en)
			buf_q[fill_q] <= push_word;
		if (state_q == sha512_pkg::ST_ROUND)
			w_q[ri] <= wt;
	end

	assign done                 = (state_q == sha512_pkg::ST_EMIT);
	assign out_item.digest_word = hash_q[emit_q];
	assign out_item.word_index  = emit_q;
	assign out_item.digest_last = (state_q == sha512_pkg::ST_EMIT) && (emit_q == 3'd7);

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && emit_q != 3'd7 |=> done && emit_q == $past(emit_q) + 3'd1)
		else $error("digest words out of order");
	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != sha512_pkg::ST_ROUND |-> rnd_q == 7'd0)
		else $error("round counter not at zero outside compression");
	a_update_after: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha512_pkg::ST_UPDATE |-> $past(rnd_q) == 7'(sha512_pkg::ROUNDS - 1))
		else $error("hash update without 80 rounds");
	a_emit_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fill_q == 4'd0 && pad_q)
		else $error("digest emitted mid-block");

endmodule
